/* design/tzfp_pkg.sv */
`timescale 1ns / 1ps

package tzfp_pkg;

  // Field widths
  localparam int TempW   = 19;
  localparam int SumW    = TempW + 1;
  localparam int DutyW   = 7;
  localparam int FanBits = 6;
  localparam int NumFans = 6;
  localparam int MarginW = 15;
  localparam int NumZones = 5;

  localparam logic [MarginW-1:0] MarginReset = 15'd5000;

  typedef enum logic [2:0] {
    LVL_DEFAULT = 3'd0,
    LVL_MID     = 3'd1,
    LVL_MAX     = 3'd2,
    LVL_HIGH    = 3'd3,
    LVL_CRIT    = 3'd4
  } level_e;

  typedef enum logic [1:0] {
    ST_DONE         = 2'd0,
    ST_SENSOR_FAULT = 2'd1,
    ST_DUTY_FAULT   = 2'd2
  } status_e;

  // Zone tables, row 0 front-to-back, row 1 back-to-front.
  // Lower bound exclusive, upper bound inclusive, millidegrees.
  localparam logic signed [SumW-1:0] ZoneLo [2][NumZones] = '{
    '{20'sd0, 20'sd39000, 20'sd46000, 20'sd50000, 20'sd55000},
    '{20'sd0, 20'sd32000, 20'sd35000, 20'sd40000, 20'sd45000}
  };
  localparam logic signed [SumW-1:0] ZoneHi [2][NumZones] = '{
    '{20'sd39000, 20'sd46000, 20'sd50000, 20'sd55000, 20'sd200000},
    '{20'sd32000, 20'sd35000, 20'sd40000, 20'sd45000, 20'sd200000}
  };
  localparam logic [DutyW-1:0] ZoneDuty [2][NumZones] = '{
    '{7'd50, 7'd75, 7'd100, 7'd100, 7'd100},
    '{7'd75, 7'd100, 7'd100, 7'd100, 7'd100}
  };

  // One management tick
  typedef struct packed {
    logic                     airflow_back_to_front;
    logic                     sensor_a_ok;
    logic signed [TempW-1:0]  sensor_a_mc;
    logic                     sensor_b_ok;
    logic signed [TempW-1:0]  sensor_b_mc;
    logic                     duty_read_ok;
    logic [DutyW-1:0]         duty_readback;
    logic [FanBits-1:0]       fan_query_ok;
    logic [FanBits-1:0]       fan_present;
    logic [FanBits-1:0]       fan_failed;
  } tick_t;

  // Classification of the averaged temperature
  typedef struct packed {
    level_e                  level;
    logic [DutyW-1:0]        duty;
    logic [DutyW-1:0]        mid_duty;
    logic signed [SumW-1:0]  temp;
    logic signed [SumW-1:0]  high_lo;
  } zone_t;

  // One result
  typedef struct packed {
    status_e          tick_status;
    level_e           zone_level;
    logic             zone_duty_write;
    logic [DutyW-1:0] zone_duty_value;
    logic             full_speed_write;
    logic             alarm_raise;
    logic             alarm_clear;
    logic             reboot_request;
  } result_t;

endpackage

/* design/tzfp_zone.sv */
`timescale 1ns / 1ps

module tzfp_zone (
  input  tzfp_pkg::tick_t tick_i,
  output tzfp_pkg::zone_t zone_o
);

  logic signed [tzfp_pkg::SumW-1:0] sum;
  logic signed [tzfp_pkg::SumW-1:0] sum_adj;
  logic signed [tzfp_pkg::SumW-1:0] temp;
  tzfp_pkg::level_e                 level;
  logic                             dir;

  assign dir = tick_i.airflow_back_to_front;

  // Average the readings, truncating toward zero
  always_comb begin
    sum     = {tick_i.sensor_a_mc[tzfp_pkg::TempW-1], tick_i.sensor_a_mc}
            + {tick_i.sensor_b_mc[tzfp_pkg::TempW-1], tick_i.sensor_b_mc};
    sum_adj = sum + {{(tzfp_pkg::SumW-1){1'b0}}, sum[tzfp_pkg::SumW-1]};
    temp    = sum_adj >>> 1;
  end

  // Match against the zone table; no match means default
  always_comb begin
    level = tzfp_pkg::LVL_DEFAULT;
    for (int i = 0; i < tzfp_pkg::NumZones; i++) begin
      if (temp > tzfp_pkg::ZoneLo[dir][i] && temp <= tzfp_pkg::ZoneHi[dir][i]) begin
        level = tzfp_pkg::level_e'(3'(i));
      end
    end
  end

  always_comb begin
    zone_o.level    = level;
    zone_o.duty     = tzfp_pkg::ZoneDuty[dir][level];
    zone_o.mid_duty = tzfp_pkg::ZoneDuty[dir][tzfp_pkg::LVL_MID];
    zone_o.temp     = temp;
    zone_o.high_lo  = tzfp_pkg::ZoneLo[dir][tzfp_pkg::LVL_HIGH];
  end

endmodule

/* design/tzfp_policy.sv */
`timescale 1ns / 1ps

module tzfp_policy (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tzfp_pkg::MarginW-1:0]   cfg_wdata_i,
  input  logic                           advance_i,
  input  tzfp_pkg::tick_t                tick_i,
  input  tzfp_pkg::zone_t                zone_i,
  output tzfp_pkg::result_t              result_o
);

  tzfp_pkg::level_e               level_q, level_d;
  logic                           alarm_q, alarm_d;
  logic                           fault_q, fault_d;
  logic [tzfp_pkg::MarginW-1:0]   margin_q;

  logic                           fan_bad;
  logic signed [tzfp_pkg::SumW-1:0] clear_thr;
  logic                           raise;
  logic                           clr;

  // Scan the fans; a fan beyond the field width counts as a failed query
  always_comb begin
    fan_bad = 1'b0;
    for (int i = 0; i < tzfp_pkg::NumFans; i++) begin
      if (i < tzfp_pkg::FanBits) begin
        fan_bad = fan_bad | ~tick_i.fan_query_ok[i] | ~tick_i.fan_present[i]
                | tick_i.fan_failed[i];
      end else begin
        fan_bad = 1'b1;
      end
    end
  end

  assign clear_thr = zone_i.high_lo - {{(tzfp_pkg::SumW-tzfp_pkg::MarginW){1'b0}}, margin_q};

  // Evaluate the tick and the next state
  always_comb begin
    level_d  = level_q;
    alarm_d  = alarm_q;
    fault_d  = fault_q;
    raise    = 1'b0;
    clr      = 1'b0;
    result_o = '0;
    result_o.tick_status = tzfp_pkg::ST_DONE;

    if (!tick_i.sensor_a_ok || !tick_i.sensor_b_ok) begin
      result_o.tick_status     = tzfp_pkg::ST_SENSOR_FAULT;
      result_o.zone_duty_write = 1'b1;
      result_o.zone_duty_value = zone_i.mid_duty;
    end else if (!tick_i.duty_read_ok) begin
      result_o.tick_status = tzfp_pkg::ST_DUTY_FAULT;
    end else begin
      if (!fault_q && tick_i.duty_readback != zone_i.duty) begin
        result_o.zone_duty_write = 1'b1;
        result_o.zone_duty_value = zone_i.duty;
      end
      fault_d                   = fan_bad;
      result_o.full_speed_write = fan_bad;

      if (zone_i.level != level_q) begin
        level_d = zone_i.level;
        if (zone_i.level == tzfp_pkg::LVL_HIGH && level_q < tzfp_pkg::LVL_HIGH && !alarm_q) begin
          raise = 1'b1;
        end
        if (zone_i.level == tzfp_pkg::LVL_CRIT && level_q < tzfp_pkg::LVL_CRIT) begin
          result_o.reboot_request = 1'b1;
        end
      end

      // A raise implies the high level, so clearing looks at the old alarm
      if (alarm_q && zone_i.level < tzfp_pkg::LVL_HIGH && zone_i.temp < clear_thr) begin
        clr = 1'b1;
      end
      alarm_d = (alarm_q | raise) & ~clr;
    end

    result_o.zone_level  = level_d;
    result_o.alarm_raise = raise;
    result_o.alarm_clear = clr;
  end

  // Hold policy state; advance only when a transaction moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= tzfp_pkg::LVL_DEFAULT;
      alarm_q  <= 1'b0;
      fault_q  <= 1'b0;
      margin_q <= tzfp_pkg::MarginReset;
    end else begin
      if (advance_i) begin
        level_q <= level_d;
        alarm_q <= alarm_d;
        fault_q <= fault_d;
      end
      if (cfg_we_i) begin
        margin_q <= cfg_wdata_i;
      end
    end
  end

endmodule

/* design/thermal_zone_fan_policy.sv */
`timescale 1ns / 1ps
// An accepted tick is held in the input register, then its result in the result register.
// Throughput: one tick per cycle unless m_axis_tready stalls; the policy state updates as a
// tick moves from the input to the result register, so the next tick sees it at once.
// Reset (rst_ni, async, active low): level default, alarm and fan fault clear,
// alarm clear margin 5000, both pipeline registers empty.

module thermal_zone_fan_policy (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration: alarm clear margin
  input  logic                         cfg_we_i,
  input  logic [tzfp_pkg::MarginW-1:0] cfg_wdata_i,
  // Input ticks
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [0] sensor_a_ok, [19:1] sensor_a_mc, [20] sensor_b_ok, [39:21] sensor_b_mc,
  // [40] duty_read_ok, [47:41] duty_readback, [53:48] fan_query_ok,
  // [59:54] fan_present, [65:60] fan_failed, [71:66] zero
  input  logic [71:0]                  s_axis_tdata,
  // [0] airflow_back_to_front
  input  logic                         s_axis_tuser,
  // Results
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [1:0] tick_status, [4:2] zone_level, [5] zone_duty_write, [12:6] zone_duty_value,
  // [13] full_speed_write, [14] alarm_raise, [15] alarm_clear, [16] reboot_request,
  // [23:17] zero
  output logic [23:0]                  m_axis_tdata
);

  tzfp_pkg::tick_t   tick_in;
  tzfp_pkg::tick_t   tick_q;
  logic              tick_valid_q;
  tzfp_pkg::zone_t   zone;
  tzfp_pkg::result_t result;
  tzfp_pkg::result_t result_q;
  logic              result_valid_q;
  logic              advance;

  // Unpack the input transaction
  always_comb begin
    tick_in.airflow_back_to_front = s_axis_tuser;
    tick_in.sensor_a_ok           = s_axis_tdata[0];
    tick_in.sensor_a_mc           = s_axis_tdata[19:1];
    tick_in.sensor_b_ok           = s_axis_tdata[20];
    tick_in.sensor_b_mc           = s_axis_tdata[39:21];
    tick_in.duty_read_ok          = s_axis_tdata[40];
    tick_in.duty_readback         = s_axis_tdata[47:41];
    tick_in.fan_query_ok          = s_axis_tdata[53:48];
    tick_in.fan_present           = s_axis_tdata[59:54];
    tick_in.fan_failed            = s_axis_tdata[65:60];
  end

  // Move a tick forward when the result register is free or being drained
  assign advance       = tick_valid_q && (!result_valid_q || m_axis_tready);
  assign s_axis_tready = !tick_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      tick_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      tick_q <= tick_in;
    end
  end

  tzfp_zone u_zone (
    .tick_i (tick_q),
    .zone_o (zone)
  );

  tzfp_policy u_policy (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .tick_i      (tick_q),
    .zone_i      (zone),
    .result_o    (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else if (advance) begin
      result_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      result_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result;
    end
  end

  // Pack the result transaction
  assign m_axis_tvalid = result_valid_q;
  assign m_axis_tdata  = {7'd0,
                          result_q.reboot_request,
                          result_q.alarm_clear,
                          result_q.alarm_raise,
                          result_q.full_speed_write,
                          result_q.zone_duty_value,
                          result_q.zone_duty_write,
                          result_q.zone_level,
                          result_q.tick_status};

endmodule
